>>> rtl/depth_pixel_backprojection_core_defines.svh
// Assertion helpers for the checker file of this block.
`ifndef DEPTH_PIXEL_BACKPROJECTION_CORE_DEFINES_SVH
`define DEPTH_PIXEL_BACKPROJECTION_CORE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define DPB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("depth backprojection check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define DPB_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("depth backprojection check failed");

`endif

>>> rtl/dpb_pkg.sv
package dpb_pkg;

	// Field widths
	localparam int COORD_W   = 12;
	localparam int DEPTH_W   = 16;
	localparam int CFG_W     = 16;
	localparam int STRIDE_W  = 4;
	localparam int COLOR_W   = 8;
	localparam int POINT_W   = 24;
	localparam int FRAC_PIX  = 4;
	localparam int POS_W     = COORD_W + FRAC_PIX;
	localparam int CFG_IDX_W = 3;

	// Columns at or above this are dropped
	localparam int unsigned MAX_IMAGE_WIDTH = 4096;

	// Divider: 32-bit product plus rounding half gives a 33-bit dividend
	localparam int NUM_W      = CFG_W + DEPTH_W;
	localparam int NUMER_W    = NUM_W + 1;
	localparam int QUO_W      = POINT_W;
	localparam int DIV_STAGES = NUMER_W;

	// Divisibility test: n % s == 0 iff (n * ceil(2^24/s)) mod 2^24 < ceil(2^24/s)
	localparam int MOD_W   = 24;
	localparam int RECIP_W = MOD_W + 1;

	// Saturation limits of the signed Q16.8 coordinates
	localparam logic [POINT_W-1:0] POS_MAX = {1'b0, {(POINT_W-1){1'b1}}};
	localparam logic [POINT_W-1:0] NEG_MIN = {1'b1, {(POINT_W-1){1'b0}}};

	// Register reset values
	localparam logic [CFG_W-1:0]    RST_CENTER_X   = 16'd5120;
	localparam logic [CFG_W-1:0]    RST_CENTER_Y   = 16'd3840;
	localparam logic [CFG_W-1:0]    RST_FOCAL_X    = 16'd8400;
	localparam logic [CFG_W-1:0]    RST_FOCAL_Y    = 16'd8400;
	localparam logic [CFG_W-1:0]    RST_DEPTH_LOW  = 16'd128;
	localparam logic [CFG_W-1:0]    RST_DEPTH_HIGH = 16'd33280;
	localparam logic [STRIDE_W-1:0] RST_STRIDE     = 4'd3;

	// Register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CENTER_X   = 3'd0,
		REG_CENTER_Y   = 3'd1,
		REG_FOCAL_X    = 3'd2,
		REG_FOCAL_Y    = 3'd3,
		REG_DEPTH_LOW  = 3'd4,
		REG_DEPTH_HIGH = 3'd5,
		REG_STRIDE     = 3'd6
	} dpb_reg_t;

	typedef struct packed {
		logic [CFG_W-1:0]    center_x;
		logic [CFG_W-1:0]    center_y;
		logic [CFG_W-1:0]    focal_x;
		logic [CFG_W-1:0]    focal_y;
		logic [CFG_W-1:0]    depth_low_limit;
		logic [CFG_W-1:0]    depth_high_limit;
		logic [STRIDE_W-1:0] sample_stride;
	} dpb_cfg_t;

	// One axis on its way into the divider
	typedef struct packed {
		logic               neg;
		logic               zero;
		logic [NUMER_W-1:0] numer;
	} dpb_axis_t;

	typedef struct packed {
		dpb_axis_t          x;
		dpb_axis_t          y;
		logic [DEPTH_W-1:0] depth;
		logic [COLOR_W-1:0] blue;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] red;
	} dpb_item_t;

	// Partial division state; sat collects quotient bits above the output width
	typedef struct packed {
		logic [CFG_W-1:0] rem;
		logic [QUO_W-1:0] quo;
		logic             sat;
	} dpb_divst_t;

	// ceil(2^24 / stride); stride zero acts as one
	function automatic logic [RECIP_W-1:0] stride_recip(input logic [STRIDE_W-1:0] s);
		logic [RECIP_W-1:0] r;
		case (s)
			4'd2:    r = 25'd8388608;
			4'd3:    r = 25'd5592406;
			4'd4:    r = 25'd4194304;
			4'd5:    r = 25'd3355444;
			4'd6:    r = 25'd2796203;
			4'd7:    r = 25'd2396746;
			4'd8:    r = 25'd2097152;
			4'd9:    r = 25'd1864136;
			4'd10:   r = 25'd1677722;
			4'd11:   r = 25'd1525202;
			4'd12:   r = 25'd1398102;
			4'd13:   r = 25'd1290556;
			4'd14:   r = 25'd1198373;
			4'd15:   r = 25'd1118482;
			default: r = 25'd16777216;
		endcase
		return r;
	endfunction

endpackage

>>> rtl/dpb_stream_if.sv
// Pixel request channel
interface dpb_pixel_if;
	import dpb_pkg::*;

	logic               valid;
	logic               ready;
	logic [COORD_W-1:0] pixel_row;
	logic [COORD_W-1:0] pixel_column;
	logic [DEPTH_W-1:0] depth_value;
	logic [COLOR_W-1:0] blue_in;
	logic [COLOR_W-1:0] green_in;
	logic [COLOR_W-1:0] red_in;

	modport source (
		output valid, pixel_row, pixel_column, depth_value, blue_in, green_in, red_in,
		input  ready
	);
	modport sink (
		input  valid, pixel_row, pixel_column, depth_value, blue_in, green_in, red_in,
		output ready
	);
endinterface

// Point request channel
interface dpb_point_if;
	import dpb_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [POINT_W-1:0] point_x;
	logic signed [POINT_W-1:0] point_y;
	logic [DEPTH_W-1:0]        point_z;
	logic [COLOR_W-1:0]        blue_out;
	logic [COLOR_W-1:0]        green_out;
	logic [COLOR_W-1:0]        red_out;

	modport source (
		output valid, point_x, point_y, point_z, blue_out, green_out, red_out,
		input  ready
	);
	modport sink (
		input  valid, point_x, point_y, point_z, blue_out, green_out, red_out,
		output ready
	);
endinterface

>>> rtl/dpb_front.sv
// Front end: pixel filter, offset from principal point, depth product, rounding half.
module dpb_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  logic [dpb_pkg::COORD_W-1:0]   row,
	input  logic [dpb_pkg::COORD_W-1:0]   column,
	input  logic [dpb_pkg::DEPTH_W-1:0]   depth,
	input  logic [dpb_pkg::COLOR_W-1:0]   blue,
	input  logic [dpb_pkg::COLOR_W-1:0]   green,
	input  logic [dpb_pkg::COLOR_W-1:0]   red,
	input  dpb_pkg::dpb_cfg_t             cfg,
	output logic                          out_valid,
	output dpb_pkg::dpb_item_t            out_item
);
	import dpb_pkg::*;

	// Stage 1 inputs
	logic [POS_W-1:0]           pos_x, pos_y;
	logic                       neg_x, neg_y;
	logic [CFG_W-1:0]           diff_x, diff_y;
	logic [RECIP_W-1:0]         recip;
	logic [COORD_W+RECIP_W-1:0] row_prod, col_prod;
	logic                       depth_ok;

	// Stage registers
	logic                 valid_s1, valid_s2, valid_s3;
	logic                 neg_x_s1, neg_y_s1, depth_ok_s1;
	logic [CFG_W-1:0]     diff_x_s1, diff_y_s1;
	logic [MOD_W-1:0]     row_mod_s1, col_mod_s1;
	logic [RECIP_W-1:0]   recip_s1;
	logic [DEPTH_W-1:0]   depth_s1, depth_s2;
	logic [COLOR_W-1:0]   blue_s1, green_s1, red_s1;
	logic [COLOR_W-1:0]   blue_s2, green_s2, red_s2;
	logic                 neg_x_s2, neg_y_s2;
	logic [NUM_W-1:0]     num_x_s2, num_y_s2;
	dpb_item_t            item_s3;
	logic                 keep;

	// Offsets from the principal point, magnitude and sign
	assign pos_x  = {column, {FRAC_PIX{1'b0}}};
	assign pos_y  = {row, {FRAC_PIX{1'b0}}};
	assign neg_x  = pos_x < cfg.center_x;
	assign neg_y  = pos_y < cfg.center_y;
	assign diff_x = neg_x ? (cfg.center_x - pos_x) : (pos_x - cfg.center_x);
	assign diff_y = neg_y ? (cfg.center_y - pos_y) : (pos_y - cfg.center_y);

	// Reciprocal products for the stride test
	assign recip    = stride_recip(cfg.sample_stride);
	assign row_prod = {{RECIP_W{1'b0}}, row} * {{COORD_W{1'b0}}, recip};
	assign col_prod = {{RECIP_W{1'b0}}, column} * {{COORD_W{1'b0}}, recip};

	// Depth window and image width
	assign depth_ok = (depth >= cfg.depth_low_limit) && (depth <= cfg.depth_high_limit)
		&& (32'(column) < MAX_IMAGE_WIDTH);

	// Stride divisibility on both coordinates
	assign keep = depth_ok_s1 && ({1'b0, row_mod_s1} < recip_s1)
		&& ({1'b0, col_mod_s1} < recip_s1);

	// Valid bits; filtered pixels turn into bubbles at stage 2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1 && keep;
			valid_s3 <= valid_s2;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (en) begin
			// stage 1
			neg_x_s1    <= neg_x;
			neg_y_s1    <= neg_y;
			diff_x_s1   <= diff_x;
			diff_y_s1   <= diff_y;
			depth_ok_s1 <= depth_ok;
			row_mod_s1  <= row_prod[MOD_W-1:0];
			col_mod_s1  <= col_prod[MOD_W-1:0];
			recip_s1    <= recip;
			depth_s1    <= depth;
			blue_s1     <= blue;
			green_s1    <= green;
			red_s1      <= red;
			// stage 2: exact offset times depth
			neg_x_s2    <= neg_x_s1;
			neg_y_s2    <= neg_y_s1;
			num_x_s2    <= NUM_W'(diff_x_s1) * NUM_W'(depth_s1);
			num_y_s2    <= NUM_W'(diff_y_s1) * NUM_W'(depth_s1);
			depth_s2    <= depth_s1;
			blue_s2     <= blue_s1;
			green_s2    <= green_s1;
			red_s2      <= red_s1;
			// stage 3: add half the focal length for round to nearest
			item_s3.x.neg   <= neg_x_s2;
			item_s3.x.zero  <= (num_x_s2 == '0);
			item_s3.x.numer <= {1'b0, num_x_s2} + NUMER_W'(cfg.focal_x >> 1);
			item_s3.y.neg   <= neg_y_s2;
			item_s3.y.zero  <= (num_y_s2 == '0);
			item_s3.y.numer <= {1'b0, num_y_s2} + NUMER_W'(cfg.focal_y >> 1);
			item_s3.depth   <= depth_s2;
			item_s3.blue    <= blue_s2;
			item_s3.green   <= green_s2;
			item_s3.red     <= red_s2;
		end
	end

	assign out_valid = valid_s3;
	assign out_item  = item_s3;

endmodule

>>> rtl/dpb_divider.sv
// Restoring divider, one quotient bit per stage, both axes side by side.
module dpb_divider (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  dpb_pkg::dpb_item_t          in_item,
	input  logic [dpb_pkg::CFG_W-1:0]   focal_x,
	input  logic [dpb_pkg::CFG_W-1:0]   focal_y,
	output logic                        out_valid,
	output dpb_pkg::dpb_item_t          out_item,
	output dpb_pkg::dpb_divst_t         out_qx,
	output dpb_pkg::dpb_divst_t         out_qy
);
	import dpb_pkg::*;

	localparam dpb_divst_t DIV_START = '0;

	logic       valid_s [DIV_STAGES];
	dpb_item_t  item_s  [DIV_STAGES];
	dpb_divst_t qx_s    [DIV_STAGES];
	dpb_divst_t qy_s    [DIV_STAGES];

	// One compare and subtract; a zero divisor always subtracts and saturates
	function automatic dpb_divst_t div_step(input dpb_divst_t st, input logic nbit,
			input logic [CFG_W-1:0] d);
		logic [CFG_W:0] trial;
		dpb_divst_t     res;
		trial   = {st.rem, nbit};
		res.sat = st.sat | st.quo[QUO_W-1];
		if (trial >= {1'b0, d}) begin
			res.rem = CFG_W'(trial - {1'b0, d});
			res.quo = {st.quo[QUO_W-2:0], 1'b1};
		end else begin
			res.rem = trial[CFG_W-1:0];
			res.quo = {st.quo[QUO_W-2:0], 1'b0};
		end
		return res;
	endfunction

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DIV_STAGES; k++) begin
				valid_s[k] <= 1'b0;
			end
		end else if (en) begin
			valid_s[0] <= in_valid;
			for (int k = 1; k < DIV_STAGES; k++) begin
				valid_s[k] <= valid_s[k-1];
			end
		end
	end

	// Dividend bits enter from the top, one per stage
	always_ff @(posedge clk) begin
		if (en) begin
			item_s[0] <= in_item;
			qx_s[0]   <= div_step(DIV_START, in_item.x.numer[NUMER_W-1], focal_x);
			qy_s[0]   <= div_step(DIV_START, in_item.y.numer[NUMER_W-1], focal_y);
			for (int k = 1; k < DIV_STAGES; k++) begin
				item_s[k] <= item_s[k-1];
				qx_s[k]   <= div_step(qx_s[k-1], item_s[k-1].x.numer[NUMER_W-1-k], focal_x);
				qy_s[k]   <= div_step(qy_s[k-1], item_s[k-1].y.numer[NUMER_W-1-k], focal_y);
			end
		end
	end

	assign out_valid = valid_s[DIV_STAGES-1];
	assign out_item  = item_s[DIV_STAGES-1];
	assign out_qx    = qx_s[DIV_STAGES-1];
	assign out_qy    = qy_s[DIV_STAGES-1];

endmodule

>>> rtl/dpb_emit.sv
// Sign and saturation, then the output register.
module dpb_emit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               en,
	input  logic                               in_valid,
	input  dpb_pkg::dpb_item_t                 in_item,
	input  dpb_pkg::dpb_divst_t                qx,
	input  dpb_pkg::dpb_divst_t                qy,
	output logic                               out_valid,
	output logic signed [dpb_pkg::POINT_W-1:0] point_x,
	output logic signed [dpb_pkg::POINT_W-1:0] point_y,
	output logic [dpb_pkg::DEPTH_W-1:0]        point_z,
	output logic [dpb_pkg::COLOR_W-1:0]        blue_out,
	output logic [dpb_pkg::COLOR_W-1:0]        green_out,
	output logic [dpb_pkg::COLOR_W-1:0]        red_out
);
	import dpb_pkg::*;

	logic               valid_q;
	logic [POINT_W-1:0] x_q, y_q;
	logic [DEPTH_W-1:0] z_q;
	logic [COLOR_W-1:0] blue_q, green_q, red_q;

	// Apply the sign to the magnitude and clamp to signed Q16.8
	function automatic logic [POINT_W-1:0] finish_axis(input dpb_axis_t a, input dpb_divst_t q);
		logic [POINT_W-1:0] r;
		if (a.zero) begin
			r = '0;
		end else if (a.neg) begin
			if (q.sat || (q.quo[QUO_W-1] && (q.quo[QUO_W-2:0] != '0))) begin
				r = NEG_MIN;
			end else begin
				r = POINT_W'(0) - q.quo;
			end
		end else if (q.sat || q.quo[QUO_W-1]) begin
			r = POS_MAX;
		end else begin
			r = q.quo;
		end
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_q     <= finish_axis(in_item.x, qx);
			y_q     <= finish_axis(in_item.y, qy);
			z_q     <= in_item.depth;
			blue_q  <= in_item.blue;
			green_q <= in_item.green;
			red_q   <= in_item.red;
		end
	end

	assign out_valid = valid_q;
	assign point_x   = signed'(x_q);
	assign point_y   = signed'(y_q);
	assign point_z   = z_q;
	assign blue_out  = blue_q;
	assign green_out = green_q;
	assign red_out   = red_q;

endmodule

>>> rtl/depth_pixel_backprojection_core.sv
// Back-projects depth pixels into colored 3D points with a pinhole camera model:
// x = (col - cx) * d / fx, y = (row - cy) * d / fy, z = d, x and y rounded to
// nearest (ties away from zero) and saturated to signed Q16.8. Pixels whose row or
// column is not a multiple of sample_stride, or whose depth lies outside the
// inclusive depth limits, are dropped and produce no point. One pixel is taken
// every clock while pixel.ready is high; a pixel passes 3 front stages for the
// filter, offset multiply and rounding add, 33 restoring divider stages with one
// quotient bit each, and the output register. The whole pipeline advances together:
// pixel.ready is low only while a point sits in the output register and point.ready
// is low. Registers may be written only while no pixel is in flight.
module depth_pixel_backprojection_core (
	input  logic                          clk,
	input  logic                          arst_n,
	dpb_pixel_if.sink                     pixel,
	dpb_point_if.source                   point,
	input  logic                          cfg_we,
	input  logic [dpb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [dpb_pkg::CFG_W-1:0]     cfg_wdata
);
	import dpb_pkg::*;

	dpb_cfg_t   cfg_q;
	logic       adv;
	logic       front_valid, div_valid;
	dpb_item_t  front_item, div_item;
	dpb_divst_t div_qx, div_qy;

	// Global advance: move whenever the output slot is free or being drained
	assign adv         = !point.valid || point.ready;
	assign pixel.ready = adv;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.center_x         <= RST_CENTER_X;
			cfg_q.center_y         <= RST_CENTER_Y;
			cfg_q.focal_x          <= RST_FOCAL_X;
			cfg_q.focal_y          <= RST_FOCAL_Y;
			cfg_q.depth_low_limit  <= RST_DEPTH_LOW;
			cfg_q.depth_high_limit <= RST_DEPTH_HIGH;
			cfg_q.sample_stride    <= RST_STRIDE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CENTER_X:   cfg_q.center_x         <= cfg_wdata;
				REG_CENTER_Y:   cfg_q.center_y         <= cfg_wdata;
				REG_FOCAL_X:    cfg_q.focal_x          <= cfg_wdata;
				REG_FOCAL_Y:    cfg_q.focal_y          <= cfg_wdata;
				REG_DEPTH_LOW:  cfg_q.depth_low_limit  <= cfg_wdata;
				REG_DEPTH_HIGH: cfg_q.depth_high_limit <= cfg_wdata;
				REG_STRIDE:     cfg_q.sample_stride    <= cfg_wdata[STRIDE_W-1:0];
				default: ;
			endcase
		end
	end

	// Filter and numerators
	dpb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (pixel.valid),
		.row       (pixel.pixel_row),
		.column    (pixel.pixel_column),
		.depth     (pixel.depth_value),
		.blue      (pixel.blue_in),
		.green     (pixel.green_in),
		.red       (pixel.red_in),
		.cfg       (cfg_q),
		.out_valid (front_valid),
		.out_item  (front_item)
	);

	// Division by the focal lengths
	dpb_divider u_divider (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (front_valid),
		.in_item   (front_item),
		.focal_x   (cfg_q.focal_x),
		.focal_y   (cfg_q.focal_y),
		.out_valid (div_valid),
		.out_item  (div_item),
		.out_qx    (div_qx),
		.out_qy    (div_qy)
	);

	// Saturation and output register
	dpb_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (div_valid),
		.in_item   (div_item),
		.qx        (div_qx),
		.qy        (div_qy),
		.out_valid (point.valid),
		.point_x   (point.point_x),
		.point_y   (point.point_y),
		.point_z   (point.point_z),
		.blue_out  (point.blue_out),
		.green_out (point.green_out),
		.red_out   (point.red_out)
	);

endmodule

>>> rtl/dpb_checker.sv
`include "depth_pixel_backprojection_core_defines.svh"

// Port-level checks on the back-projection core.
module dpb_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_valid,
	input logic                               in_ready,
	input logic                               out_valid,
	input logic                               out_ready,
	input logic signed [dpb_pkg::POINT_W-1:0] point_x,
	input logic signed [dpb_pkg::POINT_W-1:0] point_y,
	input logic [dpb_pkg::DEPTH_W-1:0]        point_z
);
	import dpb_pkg::*;

	// A point that is not taken stays offered
	`DPB_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)

	// With the output slot empty the pipeline never stalls its input
	`DPB_ASSERT_IMP(a_ready_when_empty, clk, arst_n, !out_valid, in_ready || !in_valid)

	// Zero depth projects onto the camera center
	`DPB_ASSERT_IMP(a_zero_depth, clk, arst_n, out_valid && (point_z == '0), (point_x == '0) && (point_y == '0))

endmodule

bind depth_pixel_backprojection_core dpb_checker u_dpb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (pixel.valid),
	.in_ready  (pixel.ready),
	.out_valid (point.valid),
	.out_ready (point.ready),
	.point_x   (point.point_x),
	.point_y   (point.point_y),
	.point_z   (point.point_z)
);

>>> test/tb_depth_pixel_backprojection_core.sv
module tb_depth_pixel_backprojection_core;
	timeunit 1ns;
	timeprecision 1ps;

	import dpb_pkg::*;

	localparam int CLK_HALF     = 6;
	localparam int RESET_CYCLES = 8;
	localparam int DRAIN_CYCLES = 50;      // pipeline is 37 deep
	localparam int HOLD_CYCLES  = 300;     // long receiver hold-off
	localparam int PHASE_ITEMS  = 275;
	localparam int CROSS_ITEMS  = 100;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_INDEX = 3'd7;

	localparam longint unsigned SAT_POS_MAG = 64'd8388607;
	localparam longint unsigned SAT_NEG_MAG = 64'd8388608;

	typedef struct packed {
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] column;
		logic [DEPTH_W-1:0] depth;
		logic [COLOR_W-1:0] blue;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] red;
	} pixel_t;

	typedef struct {
		logic signed [POINT_W-1:0] x;
		logic signed [POINT_W-1:0] y;
		logic [DEPTH_W-1:0]        z;
		logic [COLOR_W-1:0]        blue;
		logic [COLOR_W-1:0]        green;
		logic [COLOR_W-1:0]        red;
	} point_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_wdata;

	dpb_pixel_if pixel_if ();
	dpb_point_if point_if ();

	depth_pixel_backprojection_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pixel     (pixel_if),
		.point     (point_if),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// Shadow copy of the camera registers
	dpb_cfg_t camera_cfg;

	pixel_t pixel_queue[$];
	point_t point_expect[$];
	int     failures;

	// Sender burst state
	int burst_left;
	int gap_left;

	// Receiver pattern state
	int rx_cycle;
	int hold_cycles;
	bit hold_arm;
	bit hold_done;

	// Back-project one axis: round to nearest, ties away from zero, saturate
	function automatic logic [POINT_W-1:0] project_axis(input logic [COORD_W-1:0] coord,
			input logic [CFG_W-1:0] center, input logic [DEPTH_W-1:0] depth,
			input logic [CFG_W-1:0] focal);
		logic [POS_W-1:0]  pos;
		logic              neg;
		longint unsigned   diff;
		longint unsigned   num;
		longint unsigned   mag;
		pos  = {coord, 4'b0000};
		neg  = pos < center;
		diff = neg ? (64'(center) - 64'(pos)) : (64'(pos) - 64'(center));
		num  = diff * 64'(depth);
		if (num == 0)
			return '0;
		if (focal == 0)
			mag = SAT_NEG_MAG + 1;
		else
			mag = (num + 64'(focal >> 1)) / 64'(focal);
		if (neg) begin
			if (mag > SAT_NEG_MAG)
				mag = SAT_NEG_MAG;
			mag = 64'd0 - mag;
			return mag[POINT_W-1:0];
		end
		if (mag > SAT_POS_MAG)
			mag = SAT_POS_MAG;
		return mag[POINT_W-1:0];
	endfunction

	// Filter one pixel and build its point; returns 0 when the pixel is dropped
	function automatic bit backproject_pixel(input pixel_t p, input dpb_cfg_t c,
			output point_t q);
		int unsigned stride;
		stride = (c.sample_stride == 0) ? 1 : c.sample_stride;
		if (p.column >= MAX_IMAGE_WIDTH)
			return 0;
		if ((p.row % stride) != 0 || (p.column % stride) != 0)
			return 0;
		if (p.depth < c.depth_low_limit || p.depth > c.depth_high_limit)
			return 0;
		q.x     = project_axis(p.column, c.center_x, p.depth, c.focal_x);
		q.y     = project_axis(p.row, c.center_y, p.depth, c.focal_y);
		q.z     = p.depth;
		q.blue  = p.blue;
		q.green = p.green;
		q.red   = p.red;
		return 1;
	endfunction

	// Clock
	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// Known values on every input from time zero
	initial begin
		arst_n                = 1'b0;
		cfg_we                = 1'b0;
		cfg_index             = '0;
		cfg_wdata             = '0;
		pixel_if.valid        = 1'b0;
		pixel_if.pixel_row    = '0;
		pixel_if.pixel_column = '0;
		pixel_if.depth_value  = '0;
		pixel_if.blue_in      = '0;
		pixel_if.green_in     = '0;
		pixel_if.red_in       = '0;
		point_if.ready        = 1'b0;
	end

	// Pixel driver: bursts with random gaps, predicts each accepted request
	always @(posedge clk) begin
		pixel_t sent;
		pixel_t next_pixel;
		point_t predicted;
		if (!arst_n) begin
			pixel_if.valid <= 1'b0;
			burst_left = $urandom_range(1, 48);
			gap_left   = 0;
		end else if (!pixel_if.valid || pixel_if.ready) begin
			if (pixel_if.valid) begin
				sent.row    = pixel_if.pixel_row;
				sent.column = pixel_if.pixel_column;
				sent.depth  = pixel_if.depth_value;
				sent.blue   = pixel_if.blue_in;
				sent.green  = pixel_if.green_in;
				sent.red    = pixel_if.red_in;
				if (backproject_pixel(sent, camera_cfg, predicted))
					point_expect = {point_expect, predicted};
			end
			if (gap_left > 0) begin
				gap_left--;
				pixel_if.valid <= 1'b0;
			end else if (pixel_queue.size() > 0) begin
				next_pixel = pixel_queue.pop_front();
				pixel_if.valid        <= 1'b1;
				pixel_if.pixel_row    <= next_pixel.row;
				pixel_if.pixel_column <= next_pixel.column;
				pixel_if.depth_value  <= next_pixel.depth;
				pixel_if.blue_in      <= next_pixel.blue;
				pixel_if.green_in     <= next_pixel.green;
				pixel_if.red_in       <= next_pixel.red;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 48);
					gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
				end
			end else begin
				pixel_if.valid <= 1'b0;
			end
		end
	end

	task automatic check_field(input string field, input int want, input int got);
		if (want != got) begin
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
			failures++;
		end
	endtask

	// Point monitor and receiver stall pattern
	always @(posedge clk) begin
		point_t want;
		if (!arst_n) begin
			point_if.ready <= 1'b0;
			rx_cycle    = 0;
			hold_cycles = 0;
			hold_done   = 1'b0;
		end else begin
			if (point_if.valid && point_if.ready) begin
				if (point_expect.size() == 0) begin
					$display("%0t ns: unexpected point, expected none, actual x=%0d y=%0d z=%0d",
						$time, point_if.point_x, point_if.point_y, point_if.point_z);
					failures++;
				end else begin
					want = point_expect.pop_front();
					check_field("point_x", want.x, point_if.point_x);
					check_field("point_y", want.y, point_if.point_y);
					check_field("point_z", want.z, point_if.point_z);
					check_field("blue_out", want.blue, point_if.blue_out);
					check_field("green_out", want.green, point_if.green_out);
					check_field("red_out", want.red, point_if.red_out);
				end
			end
			rx_cycle++;
			if (hold_arm && !hold_done) begin
				// long hold-off so the pipeline fills and pixel.ready drops
				point_if.ready <= 1'b0;
				hold_cycles++;
				if (hold_cycles >= HOLD_CYCLES)
					hold_done = 1'b1;
			end else begin
				case ((rx_cycle / 97) % 4)
					0:       point_if.ready <= 1'b1;
					1:       point_if.ready <= 1'($urandom_range(0, 1));
					2:       point_if.ready <= ((rx_cycle % 3) != 0);
					default: point_if.ready <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	// Register write; called at a rising edge, leaves cfg_we high
	task automatic write_register(input logic [CFG_IDX_W-1:0] index,
			input logic [CFG_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_wdata <= data;
		@(posedge clk);
		case (index)
			REG_CENTER_X:   camera_cfg.center_x         = data;
			REG_CENTER_Y:   camera_cfg.center_y         = data;
			REG_FOCAL_X:    camera_cfg.focal_x          = data;
			REG_FOCAL_Y:    camera_cfg.focal_y          = data;
			REG_DEPTH_LOW:  camera_cfg.depth_low_limit  = data;
			REG_DEPTH_HIGH: camera_cfg.depth_high_limit = data;
			REG_STRIDE:     camera_cfg.sample_stride    = data[STRIDE_W-1:0];
			default:        ;
		endcase
	endtask

	task automatic apply_settings(input dpb_cfg_t c);
		write_register(REG_CENTER_X, c.center_x);
		write_register(REG_CENTER_Y, c.center_y);
		write_register(REG_FOCAL_X, c.focal_x);
		write_register(REG_FOCAL_Y, c.focal_y);
		write_register(REG_DEPTH_LOW, c.depth_low_limit);
		write_register(REG_DEPTH_HIGH, c.depth_high_limit);
		// upper bits of the stride word are not stored
		write_register(REG_STRIDE, {12'hABC, c.sample_stride});
		cfg_we <= 1'b0;
	endtask

	task automatic queue_pixel(input int row, input int column, input int depth,
			input int blue, input int green, input int red);
		pixel_t p;
		p.row    = COORD_W'(row);
		p.column = COORD_W'(column);
		p.depth  = DEPTH_W'(depth);
		p.blue   = COLOR_W'(blue);
		p.green  = COLOR_W'(green);
		p.red    = COLOR_W'(red);
		pixel_queue = {pixel_queue, p};
	endtask

	// Mostly grid-aligned pixels with in-range depth, the rest anything
	task automatic queue_random(input int count);
		int unsigned stride;
		int unsigned lo;
		int unsigned hi;
		int          row;
		int          column;
		int          depth;
		int          pick;
		stride = (camera_cfg.sample_stride == 0) ? 1 : camera_cfg.sample_stride;
		lo     = camera_cfg.depth_low_limit;
		hi     = camera_cfg.depth_high_limit;
		repeat (count) begin
			if ($urandom_range(0, 3) != 0)
				row = stride * $urandom_range(0, 4095 / stride);
			else
				row = $urandom_range(0, 4095);
			if ($urandom_range(0, 3) != 0)
				column = stride * $urandom_range(0, 4095 / stride);
			else
				column = $urandom_range(0, 4095);
			pick = $urandom_range(0, 9);
			if (pick < 7 && lo <= hi)
				depth = $urandom_range(hi, lo);
			else if (pick == 7)
				depth = lo;
			else if (pick == 8)
				depth = hi;
			else
				depth = $urandom_range(0, 65535);
			queue_pixel(row, column, depth, $urandom_range(0, 255), $urandom_range(0, 255),
				$urandom_range(0, 255));
		end
	endtask

	// Wait until every request is sent and every point is back, then let
	// dropped pixels clear the pipeline
	task automatic wait_drained();
		while (pixel_queue.size() != 0 || pixel_if.valid || point_expect.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Run limit
	initial begin
		#5_000_000;
		$display("tb: failure");
		$finish;
	end

	// Main sequence
	initial begin
		dpb_cfg_t c;
		failures   = 0;
		hold_arm   = 1'b0;
		camera_cfg = '{RST_CENTER_X, RST_CENTER_Y, RST_FOCAL_X, RST_FOCAL_Y,
			RST_DEPTH_LOW, RST_DEPTH_HIGH, RST_STRIDE};
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: limits, grid and corner pixels
		queue_pixel(0, 0, 128, 0, 0, 0);
		queue_pixel(4095, 4095, 33280, 255, 255, 255);
		queue_pixel(240, 320, 1000, 18, 52, 86);
		queue_pixel(0, 0, 127, 1, 2, 3);
		queue_pixel(0, 0, 33281, 4, 5, 6);
		queue_pixel(1, 0, 500, 7, 8, 9);
		queue_pixel(0, 1, 500, 10, 11, 12);
		queue_pixel(3, 3, 0, 13, 14, 15);
		queue_pixel(3, 3, 65535, 16, 17, 18);
		queue_pixel(243, 321, 2560, 170, 85, 204);
		queue_pixel(237, 318, 2560, 85, 170, 51);
		queue_pixel(4095, 0, 33280, 165, 90, 195);
		queue_pixel(0, 4095, 129, 60, 195, 15);
		queue_random(PHASE_ITEMS);
		wait_drained();

		// Low extremes, every pixel kept; receiver hold-off here
		c = '{16'd0, 16'd0, 16'd16, 16'd16, 16'd0, 16'd65535, 4'd1};
		apply_settings(c);
		queue_random(PHASE_ITEMS);
		hold_arm = 1'b1;
		wait_drained();

		// High extremes
		c = '{16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd0, 16'd65535, 4'd8};
		apply_settings(c);
		queue_random(PHASE_ITEMS);
		wait_drained();

		// Zero stride, zero focal_x, focal_y below its range
		c.center_x         = 16'($urandom_range(0, 4095) * 16);
		c.center_y         = 16'($urandom_range(0, 65535));
		c.focal_x          = 16'd0;
		c.focal_y          = 16'($urandom_range(1, 15));
		c.depth_low_limit  = 16'd0;
		c.depth_high_limit = 16'($urandom_range(30000, 65535));
		c.sample_stride    = 4'd0;
		apply_settings(c);
		queue_pixel($urandom_range(0, 4095), c.center_x >> 4, 2000, 33, 66, 99);
		queue_pixel($urandom_range(0, 4095), $urandom_range(0, 4095), 0, 44, 88, 132);
		queue_random(PHASE_ITEMS);
		wait_drained();

		// Crossed limits: nothing passes; write to an unknown index as well
		write_register(REG_UNUSED_INDEX, 16'hFFFF);
		c = '{16'd1000, 16'd2000, 16'd300, 16'd400, 16'd40000, 16'd39999, 4'd13};
		apply_settings(c);
		queue_random(CROSS_ITEMS);
		wait_drained();

		// Random intrinsics, stride above eight
		c.center_x         = 16'($urandom_range(0, 65535));
		c.center_y         = 16'($urandom_range(0, 65535));
		c.focal_x          = 16'($urandom_range(16, 65535));
		c.focal_y          = 16'($urandom_range(16, 65535));
		c.depth_low_limit  = 16'($urandom_range(0, 2000));
		c.depth_high_limit = 16'($urandom_range(20000, 65535));
		c.sample_stride    = 4'($urandom_range(9, 15));
		apply_settings(c);
		queue_random(PHASE_ITEMS);
		wait_drained();

		// Small focal_x, zero focal_y, single accepted depth
		c.center_x         = 16'($urandom_range(0, 65535));
		c.center_y         = 16'($urandom_range(0, 65535));
		c.focal_x          = 16'($urandom_range(1, 15));
		c.focal_y          = 16'd0;
		c.depth_low_limit  = 16'($urandom_range(1, 65535));
		c.depth_high_limit = c.depth_low_limit;
		c.sample_stride    = 4'($urandom_range(2, 8));
		apply_settings(c);
		queue_random(PHASE_ITEMS);
		wait_drained();

		if (point_expect.size() != 0)
			failures++;
		if (failures == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

>>> depth_pixel_backprojection_core.f
+incdir+rtl
rtl/dpb_pkg.sv
rtl/dpb_stream_if.sv
rtl/dpb_front.sv
rtl/dpb_divider.sv
rtl/dpb_emit.sv
rtl/depth_pixel_backprojection_core.sv
rtl/dpb_checker.sv
test/tb_depth_pixel_backprojection_core.sv
